// ===== rtl/bcm_pkg.sv =====
// Shared types, constants and helper functions for the banked cartridge mapper.
// Used by the RAM module and by the top level; depends on nothing else.
package bcm_pkg;

  localparam int RAM_BANK_COUNT = 4;
  localparam int RAM_BANK_BYTES = 8192;
  localparam int ROM_BANK_BITS  = 7;

  localparam int RAM_DEPTH  = RAM_BANK_COUNT * RAM_BANK_BYTES;
  localparam int RAM_AW     = $clog2(RAM_DEPTH);
  localparam int RAM_OFF_W  = $clog2(RAM_BANK_BYTES);
  localparam int RAM_BANK_W = (RAM_BANK_COUNT > 1) ? $clog2(RAM_BANK_COUNT) : 1;

  localparam int ROM_ADDR_W = 21;
  localparam int ROM_OFF_W  = 14;
  localparam int LATCH_N    = 5;
  localparam int LATCH_W    = $clog2(LATCH_N);

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic {
    CFG_HAS_CLOCK = 1'b0,
    CFG_ROM_MASK  = 1'b1
  } cfg_idx_e;

  // Bus regions decoded from address bits 15:13.
  localparam logic [2:0] AREA_RAM_EN   = 3'd0;
  localparam logic [2:0] AREA_ROM_BANK = 3'd1;
  localparam logic [2:0] AREA_SELECT   = 3'd2;
  localparam logic [2:0] AREA_LATCH    = 3'd3;
  localparam logic [2:0] AREA_EXT_RAM  = 3'd5;

  localparam logic [3:0] SEL_RAM_LAST  = 4'h3;
  localparam logic [3:0] SEL_SECONDS   = 4'h8;
  localparam logic [3:0] SEL_MINUTES   = 4'h9;
  localparam logic [3:0] SEL_HOURS     = 4'hA;
  localparam logic [3:0] SEL_DAYS_LOW  = 4'hB;
  localparam logic [3:0] SEL_DAYS_HIGH = 4'hC;

  localparam logic [3:0] RAM_EN_KEY  = 4'hA;
  localparam logic [7:0] BYTE_OPEN   = 8'hFF;
  localparam int         HALT_POS    = 6;
  localparam int         CARRY_POS   = 7;
  localparam logic [9:0] DAYS_WRAP   = 10'h200;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [RAM_AW-1:0] addr;
    logic [7:0]        wdata;
  } ram_req_t;

  function automatic logic [7:0] mod60(input logic [7:0] v);
    logic [7:0] r;
    r = v;
    if (r >= 8'd240) r = r - 8'd240;
    if (r >= 8'd120) r = r - 8'd120;
    if (r >= 8'd60)  r = r - 8'd60;
    return r;
  endfunction

  function automatic logic [7:0] mod24(input logic [7:0] v);
    logic [7:0] r;
    r = v;
    if (r >= 8'd192) r = r - 8'd192;
    if (r >= 8'd96)  r = r - 8'd96;
    if (r >= 8'd48)  r = r - 8'd48;
    if (r >= 8'd24)  r = r - 8'd24;
    return r;
  endfunction

  function automatic logic [RAM_BANK_W-1:0] ram_bank(input logic [1:0] sel);
    logic [2:0] s;
    s = {1'b0, sel};
    if (RAM_BANK_COUNT == 1) begin
      s = '0;
    end else if (s >= 3'(RAM_BANK_COUNT)) begin
      s = s - 3'(RAM_BANK_COUNT);
    end
    return RAM_BANK_W'(s);
  endfunction

endpackage

// ===== rtl/bcm_ram.sv =====
// Single-port cartridge RAM with a registered read port.
// Depends on bcm_pkg for the depth and the request struct.
module bcm_ram (
  input  logic              clk_i,
  input  bcm_pkg::ram_req_t req_i,
  output logic [7:0]        rdata_o
);
  import bcm_pkg::*;

  logic [7:0] mem [RAM_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/banked_cartridge_mapper_rtc.sv =====
// Top level of the banked cartridge mapper with real-time clock.
// Depends on bcm_pkg and bcm_ram.

// The block accepts one item per clock cycle unless the output stalls it. Its result is
// registered first by the synchronous RAM read or by stage one, then in the output
// register. All mapper and clock state is updated at the edge that accepts an item, so a
// read always sees every earlier write. The 32 KiB RAM is a single-port memory that is
// not cleared after reset; reads of bytes never written return undefined data.
module banked_cartridge_mapper_rtc (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // address[15:0], wdata[23:16]
  input  logic [1:0]  s_axis_tuser_i,   // cmd[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // rdata[7:0], rom_addr[28:8], zero[31:29]
  output logic        m_axis_tuser_o,   // rom_read[0]
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [20:0] cfg_wdata_i
);
  import bcm_pkg::*;

  logic                     has_clock_q;
  logic [ROM_ADDR_W-1:0]    rom_mask_q;
  logic                     ram_en_q, ram_en_d;
  logic [ROM_BANK_BITS-1:0] rom_bank_q, rom_bank_d;
  logic [3:0]               sel_q, sel_d;
  logic [7:0]               last_latch_q, last_latch_d;
  logic [7:0]               sec_q, sec_d, min_q, min_d, hr_q, hr_d;
  logic [7:0]               dl_q, dl_d, dh_q, dh_d;
  logic [7:0]               latched_q [LATCH_N];
  logic [7:0]               latched_d [LATCH_N];

  logic                     s1_v_q, s1_v_d;
  logic                     s1_use_ram_q, s1_use_ram_d;
  logic [7:0]               s1_rdata_q, s1_rdata_d;
  logic                     s1_rom_q, s1_rom_d;
  logic [ROM_ADDR_W-1:0]    s1_addr_q, s1_addr_d;
  logic                     out_v_q, out_v_d;
  logic [7:0]               out_rdata_q;
  logic                     out_rom_q;
  logic [ROM_ADDR_W-1:0]    out_addr_q;

  logic                     acc, s1_adv;
  cmd_e                     cmd;
  logic [15:0]              address;
  logic [7:0]               wdata;
  ram_req_t                 ram_req;
  logic [7:0]               ram_rdata;
  logic [RAM_AW-1:0]        ram_addr;
  logic [ROM_ADDR_W-1:0]    rom_full;
  logic [LATCH_W-1:0]       lat_idx;
  logic                     sel_ram, sel_clock;

  logic [7:0]               t_sec, t_min, t_hr, t_dh;
  logic [9:0]               t_days;

  assign cmd     = cmd_e'(s_axis_tuser_i);
  assign address = s_axis_tdata_i[15:0];
  assign wdata   = s_axis_tdata_i[23:16];

  assign s1_adv          = s1_v_q && (!out_v_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_v_q || s1_adv;
  assign acc             = s_axis_tvalid_i && s_axis_tready_o;

  assign ram_addr  = RAM_AW'({ram_bank(sel_q[1:0]), address[RAM_OFF_W-1:0]});
  assign rom_full  = address[ROM_OFF_W] ? ROM_ADDR_W'({rom_bank_q, address[ROM_OFF_W-1:0]})
                                        : ROM_ADDR_W'(address[ROM_OFF_W-1:0]);
  assign lat_idx   = LATCH_W'(sel_q - SEL_SECONDS);
  assign sel_ram   = (sel_q <= SEL_RAM_LAST);
  assign sel_clock = has_clock_q && (sel_q >= SEL_SECONDS) && (sel_q <= SEL_DAYS_HIGH);

  always_comb begin
    t_sec  = sec_q + 8'd1;
    t_min  = min_q;
    t_hr   = hr_q;
    t_dh   = dh_q;
    t_days = {1'b0, dh_q[0], dl_q};
    if (t_sec >= 8'd60) begin
      t_sec = t_sec - 8'd60;
      t_min = t_min + 8'd1;
    end
    if (t_min >= 8'd60) begin
      t_min = t_min - 8'd60;
      t_hr  = t_hr + 8'd1;
    end
    if (t_hr >= 8'd24) begin
      t_hr   = t_hr - 8'd24;
      t_days = t_days + 10'd1;
    end
    if (t_days >= DAYS_WRAP) begin
      t_days          = t_days & (DAYS_WRAP - 10'd1);
      t_dh[CARRY_POS] = 1'b1;
    end
    t_dh[0] = t_days[8];
  end

  always_comb begin
    ram_en_d     = ram_en_q;
    rom_bank_d   = rom_bank_q;
    sel_d        = sel_q;
    last_latch_d = last_latch_q;
    sec_d        = sec_q;
    min_d        = min_q;
    hr_d         = hr_q;
    dl_d         = dl_q;
    dh_d         = dh_q;
    latched_d    = latched_q;
    ram_req      = '0;
    ram_req.addr  = ram_addr;
    ram_req.wdata = wdata;
    s1_use_ram_d = 1'b0;
    s1_rdata_d   = BYTE_OPEN;
    s1_rom_d     = 1'b0;
    s1_addr_d    = '0;

    if (acc) begin
      case (cmd)
        CMD_READ: begin
          if (!address[15]) begin
            s1_rom_d  = 1'b1;
            s1_addr_d = rom_full & rom_mask_q;
          end else if (address[15:13] == AREA_EXT_RAM && ram_en_q) begin
            if (sel_ram) begin
              ram_req.re   = 1'b1;
              s1_use_ram_d = 1'b1;
            end else if (sel_clock) begin
              s1_rdata_d = latched_q[lat_idx];
            end
          end
        end
        CMD_WRITE: begin
          case (address[15:13])
            AREA_RAM_EN:   ram_en_d = (wdata[3:0] == RAM_EN_KEY);
            AREA_ROM_BANK: begin
              rom_bank_d = wdata[ROM_BANK_BITS-1:0];
              if (wdata[ROM_BANK_BITS-1:0] == '0) begin
                rom_bank_d = ROM_BANK_BITS'(1);
              end
            end
            AREA_SELECT:   sel_d = wdata[3:0];
            AREA_LATCH: begin
              if (has_clock_q) begin
                if (last_latch_q == 8'h00 && wdata == 8'h01) begin
                  latched_d[0] = sec_q;
                  latched_d[1] = min_q;
                  latched_d[2] = hr_q;
                  latched_d[3] = dl_q;
                  latched_d[4] = dh_q;
                end
                last_latch_d = wdata;
              end
            end
            AREA_EXT_RAM: begin
              if (ram_en_q) begin
                if (sel_ram) begin
                  ram_req.we = 1'b1;
                end else if (has_clock_q) begin
                  case (sel_q)
                    SEL_SECONDS: begin
                      sec_d        = mod60(wdata);
                      latched_d[0] = mod60(wdata);
                    end
                    SEL_MINUTES: begin
                      min_d        = mod60(wdata);
                      latched_d[1] = mod60(wdata);
                    end
                    SEL_HOURS: begin
                      hr_d         = mod24(wdata);
                      latched_d[2] = mod24(wdata);
                    end
                    SEL_DAYS_LOW: begin
                      dl_d         = wdata;
                      latched_d[3] = wdata;
                    end
                    SEL_DAYS_HIGH: begin
                      dh_d         = wdata;
                      latched_d[4] = wdata;
                    end
                    default: ;
                  endcase
                end
              end
            end
            default: ;
          endcase
        end
        CMD_TICK: begin
          if (!dh_q[HALT_POS]) begin
            sec_d = t_sec;
            min_d = t_min;
            hr_d  = t_hr;
            dl_d  = t_days[7:0];
            dh_d  = t_dh;
          end
        end
        default: ;
      endcase
    end
  end

  assign s1_v_d  = acc ? 1'b1 : (s1_adv ? 1'b0 : s1_v_q);
  assign out_v_d = s1_adv ? 1'b1 : (m_axis_tready_i ? 1'b0 : out_v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_clock_q  <= 1'b1;
      rom_mask_q   <= '1;
      ram_en_q     <= 1'b0;
      rom_bank_q   <= ROM_BANK_BITS'(1);
      sel_q        <= '0;
      last_latch_q <= '0;
      sec_q        <= '0;
      min_q        <= '0;
      hr_q         <= '0;
      dl_q         <= '0;
      dh_q         <= '0;
      for (int i = 0; i < LATCH_N; i++) begin
        latched_q[i] <= '0;
      end
      s1_v_q       <= 1'b0;
      out_v_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_HAS_CLOCK: has_clock_q <= cfg_wdata_i[0];
          CFG_ROM_MASK:  rom_mask_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
      ram_en_q     <= ram_en_d;
      rom_bank_q   <= rom_bank_d;
      sel_q        <= sel_d;
      last_latch_q <= last_latch_d;
      sec_q        <= sec_d;
      min_q        <= min_d;
      hr_q         <= hr_d;
      dl_q         <= dl_d;
      dh_q         <= dh_d;
      latched_q    <= latched_d;
      s1_v_q       <= s1_v_d;
      out_v_q      <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_use_ram_q <= s1_use_ram_d;
      s1_rdata_q   <= s1_rdata_d;
      s1_rom_q     <= s1_rom_d;
      s1_addr_q    <= s1_addr_d;
    end
    if (s1_adv) begin
      out_rdata_q <= s1_use_ram_q ? ram_rdata : s1_rdata_q;
      out_rom_q   <= s1_rom_q;
      out_addr_q  <= s1_addr_q;
    end
  end

  bcm_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {3'b000, out_addr_q, out_rdata_q};
  assign m_axis_tuser_o  = out_rom_q;

`ifndef SYNTH
  a_ram_single_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_req.we && ram_req.re))
    else $error("RAM read and write issued together");

  a_ram_needs_enable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_req.we || ram_req.re) |-> (ram_en_q && acc))
    else $error("RAM access without enable or accepted item");

  a_rom_result_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o[7:0] == BYTE_OPEN))
    else $error("ROM read result carries data");

  a_out_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(s1_v_q))
    else $error("Result appeared without a staged item");

  a_bank_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rom_bank_q != '0)
    else $error("ROM bank register holds zero");
`endif

endmodule
